>>> hdl/rwhp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwhp_pkg
// Shared types and constants for the RIFF/WAVE header parser.
// ----------------------------------------------------------------------------
package rwhp_pkg;

	localparam logic [31:0] TAG_RIFF   = 32'h52494646; // "RIFF"
	localparam logic [31:0] TAG_WAVE   = 32'h57415645; // "WAVE"
	localparam logic [31:0] TAG_FMT    = 32'h666d7420; // "fmt "
	localparam logic [31:0] TAG_DATA   = 32'h64617461; // "data"
	localparam logic [31:0] HUGE_SIZE  = 32'h7fff0000;
	localparam logic [31:0] EXTENSIBLE = 32'h0000fffe;
	localparam logic [31:0] FMT_BASE   = 32'd16;
	localparam logic [31:0] FMT_EXT    = 32'd28;
	localparam logic [31:0] EXT_GAP    = 32'd8;
	localparam logic [31:0] SUB_HDR    = 32'd8;
	localparam logic [31:0] FORM_LEN   = 32'd4;

	typedef enum logic [15:0] {
		PH_TAG      = 16'h0001,
		PH_SIZE     = 16'h0002,
		PH_FORM     = 16'h0004,
		PH_SUBTAG   = 16'h0008,
		PH_SUBSIZE  = 16'h0010,
		PH_F_FMT    = 16'h0020,
		PH_F_CH     = 16'h0040,
		PH_F_RATE   = 16'h0080,
		PH_F_BRATE  = 16'h0100,
		PH_F_ALIGN  = 16'h0200,
		PH_F_BITS   = 16'h0400,
		PH_EXT_SKIP = 16'h0800,
		PH_EXT_FMT  = 16'h1000,
		PH_SKIP_SUB = 16'h2000,
		PH_SKIP_OUT = 16'h4000,
		PH_DONE     = 16'h8000
	} phase_t;

	typedef struct packed {
		logic [7:0] file_byte;
		logic       end_of_file;
	} byte_req_t;

	typedef struct packed {
		logic [31:0] audio_format;
		logic [15:0] channel_count;
		logic [31:0] sample_rate;
		logic [31:0] byte_rate;
		logic [15:0] block_align;
		logic [15:0] bits_per_sample;
		logic [31:0] data_length;
		logic [31:0] data_offset;
		logic        is_streamed;
		logic        header_ok;
		logic        data_found;
	} header_t;

endpackage

>>> hdl/rwhp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwhp_if
// Valid/ready channels: file byte stream in, header request out.
// ----------------------------------------------------------------------------
interface rwhp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] file_byte;
	logic       end_of_file;

	modport source (output valid, output file_byte, output end_of_file, input ready);
	modport sink (input valid, input file_byte, input end_of_file, output ready);
endinterface

interface rwhp_header_if;
	logic        valid;
	logic        ready;
	logic [31:0] audio_format;
	logic [15:0] channel_count;
	logic [31:0] sample_rate;
	logic [31:0] byte_rate;
	logic [15:0] block_align;
	logic [15:0] bits_per_sample;
	logic [31:0] data_length;
	logic [31:0] data_offset;
	logic        is_streamed;
	logic        header_ok;
	logic        data_found;

	modport source (output valid, output audio_format, output channel_count,
		output sample_rate, output byte_rate, output block_align, output bits_per_sample,
		output data_length, output data_offset, output is_streamed, output header_ok,
		output data_found, input ready);
	modport sink (input valid, input audio_format, input channel_count,
		input sample_rate, input byte_rate, input block_align, input bits_per_sample,
		input data_length, input data_offset, input is_streamed, input header_ok,
		input data_found, output ready);
endinterface

>>> hdl/rwhp_parse_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwhp_parse_core
// Chunk walker state and one-byte update; emit is valid before step.
// ----------------------------------------------------------------------------
module rwhp_parse_core import rwhp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  byte_req_t req,
	output logic      emit,
	output header_t   result
);

	phase_t      phase_q, phase_n;
	logic [1:0]  fbc_q, fbc_n;
	logic [31:0] asm_q, asm_n;
	logic [31:0] outer_q, outer_n;
	logic [31:0] sub_size_q, sub_size_n;
	logic [31:0] skip_q, skip_n;
	logic [31:0] pos_q, pos_n;
	logic [31:0] sub_tag_q, sub_tag_n;
	logic [31:0] fmt_q, fmt_n;
	logic [31:0] rate_q, rate_n;
	logic [31:0] brate_q, brate_n;
	logic [15:0] chan_q, chan_n;
	logic [15:0] align_q, align_n;
	logic [15:0] bits_q, bits_n;
	logic        found_q, found_n;
	logic [31:0] dpos_q, dpos_n;
	logic [31:0] dsize_q, dsize_n;
	logic        strm_q, strm_n;
	logic        sent_q;

	always_comb begin
		logic [31:0] w_be;
		logic [31:0] w_le;
		logic [31:0] w;
		logic [31:0] sz;
		logic [31:0] o1;
		logic [31:0] rem;
		logic [2:0]  cnt;
		logic        len2;
		logic        be;
		logic        complete;
		logic        emit_data;
		logic        req_inner;
		logic        req_so;
		logic [31:0] arg_o;
		logic [31:0] arg_n;

		phase_n    = phase_q;
		fbc_n      = fbc_q;
		asm_n      = asm_q;
		outer_n    = outer_q;
		sub_size_n = sub_size_q;
		skip_n     = skip_q;
		pos_n      = pos_q + 32'd1;
		sub_tag_n  = sub_tag_q;
		fmt_n      = fmt_q;
		rate_n     = rate_q;
		brate_n    = brate_q;
		chan_n     = chan_q;
		align_n    = align_q;
		bits_n     = bits_q;
		found_n    = found_q;
		dpos_n     = dpos_q;
		dsize_n    = dsize_q;
		strm_n     = strm_q;
		emit_data  = 1'b0;
		req_inner  = 1'b0;
		req_so     = 1'b0;
		arg_o      = outer_q;
		arg_n      = outer_q;
		sz         = 32'd0;
		o1         = outer_q - SUB_HDR;
		rem        = 32'd0;

		w_be = {asm_q[23:0], req.file_byte};
		w_le = asm_q | ({24'd0, req.file_byte} << {fbc_q, 3'b000});
		len2 = (phase_q == PH_F_FMT) || (phase_q == PH_F_CH) ||
			(phase_q == PH_F_ALIGN) || (phase_q == PH_F_BITS);
		be   = (phase_q == PH_TAG) || (phase_q == PH_FORM) || (phase_q == PH_SUBTAG);
		w    = be ? w_be : w_le;
		cnt  = {1'b0, fbc_q} + 3'd1;
		complete = len2 ? (cnt == 3'd2) : (cnt == 3'd4);

		unique case (phase_q)
			PH_DONE: begin
			end
			PH_SKIP_SUB, PH_SKIP_OUT, PH_EXT_SKIP: begin
				skip_n = skip_q - 32'd1;
				if (skip_n == 32'd0) begin
					priority case (phase_q)
						PH_SKIP_SUB: begin
							req_inner = 1'b1;
							arg_o     = outer_q;
						end
						PH_SKIP_OUT: phase_n = PH_TAG;
						default:     phase_n = PH_EXT_FMT;
					endcase
				end
			end
			default: begin
				if (!complete) begin
					asm_n = w;
					fbc_n = cnt[1:0];
				end else begin
					asm_n = 32'd0;
					fbc_n = 2'd0;
					unique case (phase_q)
						PH_TAG: begin
							sub_tag_n = w;
							phase_n   = PH_SIZE;
						end
						PH_SIZE: begin
							sz = w;
							if (w == 32'd0 || w >= HUGE_SIZE) begin
								strm_n = 1'b1;
								sz     = 32'hffffffff;
							end
							if (sub_tag_q != TAG_RIFF || sz < FORM_LEN) begin
								req_so = 1'b1;
								arg_n  = sz;
							end else begin
								outer_n = sz;
								phase_n = PH_FORM;
							end
						end
						PH_FORM: begin
							outer_n = outer_q - FORM_LEN;
							if (w != TAG_WAVE) begin
								req_so = 1'b1;
								arg_n  = outer_n;
							end else begin
								req_inner = 1'b1;
								arg_o     = outer_n;
							end
						end
						PH_SUBTAG: begin
							sub_tag_n = w;
							phase_n   = PH_SUBSIZE;
						end
						PH_SUBSIZE: begin
							sub_size_n = w;
							outer_n    = o1;
							rem        = o1 - w;
							if (o1 < w) begin
								req_so = 1'b1;
								arg_n  = o1;
							end else if (sub_tag_q == TAG_FMT) begin
								if (w < FMT_BASE) begin
									req_so = 1'b1;
									arg_n  = o1;
								end else begin
									phase_n = PH_F_FMT;
								end
							end else begin
								if (sub_tag_q == TAG_DATA) begin
									dpos_n  = pos_n;
									dsize_n = w;
									found_n = 1'b1;
								end
								if (sub_tag_q == TAG_DATA && (w == 32'd0 || strm_q)) begin
									strm_n    = 1'b1;
									emit_data = 1'b1;
									phase_n   = PH_DONE;
								end else begin
									outer_n = rem;
									if (w == 32'd0) begin
										req_inner = 1'b1;
										arg_o     = rem;
									end else begin
										skip_n  = w;
										phase_n = PH_SKIP_SUB;
									end
								end
							end
						end
						PH_F_FMT: begin
							fmt_n   = {16'd0, w[15:0]};
							phase_n = PH_F_CH;
						end
						PH_F_CH: begin
							chan_n  = w[15:0];
							phase_n = PH_F_RATE;
						end
						PH_F_RATE: begin
							rate_n  = w;
							phase_n = PH_F_BRATE;
						end
						PH_F_BRATE: begin
							brate_n = w;
							phase_n = PH_F_ALIGN;
						end
						PH_F_ALIGN: begin
							align_n = w[15:0];
							phase_n = PH_F_BITS;
						end
						PH_F_BITS: begin
							bits_n = w[15:0];
							if (fmt_q == EXTENSIBLE) begin
								if (sub_size_q < FMT_EXT) begin
									req_so = 1'b1;
									arg_n  = outer_q;
								end else begin
									skip_n  = EXT_GAP;
									phase_n = PH_EXT_SKIP;
								end
							end else begin
								outer_n = outer_q - sub_size_q;
								sz      = sub_size_q - FMT_BASE;
								if (sz == 32'd0) begin
									req_inner = 1'b1;
									arg_o     = outer_n;
								end else begin
									skip_n  = sz;
									phase_n = PH_SKIP_SUB;
								end
							end
						end
						PH_EXT_FMT: begin
							fmt_n   = w;
							outer_n = outer_q - sub_size_q;
							sz      = sub_size_q - FMT_EXT;
							if (sz == 32'd0) begin
								req_inner = 1'b1;
								arg_o     = outer_n;
							end else begin
								skip_n  = sz;
								phase_n = PH_SKIP_SUB;
							end
						end
						default: phase_n = PH_DONE;
					endcase
				end
			end
		endcase

		// enough left for another sub-chunk header, else drain the RIFF chunk
		if (req_inner) begin
			if (arg_o >= SUB_HDR) begin
				phase_n = PH_SUBTAG;
			end else begin
				req_so = 1'b1;
				arg_n  = arg_o;
			end
		end
		if (req_so) begin
			if (arg_n == 32'd0) begin
				phase_n = PH_TAG;
			end else begin
				skip_n  = arg_n;
				phase_n = PH_SKIP_OUT;
			end
		end

		emit = (emit_data || req.end_of_file) && !sent_q;

		result.audio_format    = fmt_n;
		result.channel_count   = chan_n;
		result.sample_rate     = rate_n;
		result.byte_rate       = brate_n;
		result.block_align     = align_n;
		result.bits_per_sample = bits_n;
		result.data_length     = dsize_n;
		result.data_offset     = dpos_n;
		result.is_streamed     = strm_n;
		result.header_ok       = (fmt_n != 32'd0) && (rate_n != 32'd0);
		result.data_found      = found_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_TAG;
			fbc_q      <= '0;
			asm_q      <= '0;
			outer_q    <= '0;
			sub_size_q <= '0;
			skip_q     <= '0;
			pos_q      <= '0;
			sub_tag_q  <= '0;
			fmt_q      <= '0;
			rate_q     <= '0;
			brate_q    <= '0;
			chan_q     <= '0;
			align_q    <= '0;
			bits_q     <= '0;
			found_q    <= 1'b0;
			dpos_q     <= '0;
			dsize_q    <= '0;
			strm_q     <= 1'b0;
			sent_q     <= 1'b0;
		end else if (step) begin
			if (req.end_of_file) begin
				// last byte of the file: start over for the next one
				phase_q    <= PH_TAG;
				fbc_q      <= '0;
				asm_q      <= '0;
				outer_q    <= '0;
				sub_size_q <= '0;
				skip_q     <= '0;
				pos_q      <= '0;
				sub_tag_q  <= '0;
				fmt_q      <= '0;
				rate_q     <= '0;
				brate_q    <= '0;
				chan_q     <= '0;
				align_q    <= '0;
				bits_q     <= '0;
				found_q    <= 1'b0;
				dpos_q     <= '0;
				dsize_q    <= '0;
				strm_q     <= 1'b0;
				sent_q     <= 1'b0;
			end else begin
				phase_q    <= phase_n;
				fbc_q      <= fbc_n;
				asm_q      <= asm_n;
				outer_q    <= outer_n;
				sub_size_q <= sub_size_n;
				skip_q     <= skip_n;
				pos_q      <= pos_n;
				sub_tag_q  <= sub_tag_n;
				fmt_q      <= fmt_n;
				rate_q     <= rate_n;
				brate_q    <= brate_n;
				chan_q     <= chan_n;
				align_q    <= align_n;
				bits_q     <= bits_n;
				found_q    <= found_n;
				dpos_q     <= dpos_n;
				dsize_q    <= dsize_n;
				strm_q     <= strm_n;
				sent_q     <= sent_q | emit;
			end
		end
	end

endmodule

>>> hdl/riff_wave_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riff_wave_header_parser
// Walks RIFF/WAVE chunks from a byte stream and reports the header once.
// ----------------------------------------------------------------------------
// Usage:
//   file_bytes carries the file one byte per request; end_of_file marks the
//   last byte of a file. After that byte the parser is back in its reset
//   state and the next request starts a new file.
//   header carries one request per file: the fmt fields, the data chunk's
//   offset and length and the status flags. It is sent when the data chunk
//   of a streamed file (size zero or unknown) starts, or else with the
//   end-of-file byte. Bytes between those two points only move the counters.
// Timing:
//   A byte is held in the input register and then folded into the chunk
//   walker; the header that it raises is then captured in the output
//   register. One byte per cycle is sustained unless a header stalls, as
//   below: the walker takes each byte in a single update of its state registers.
// Stall:
//   While an unread header waits on header.ready, bytes that give no header
//   still move on; only a byte that would raise a second header waits in the
//   input register, and file_bytes.ready drops behind it.
// Reset:
//   arst_n clears the walker, the input register and the output valid.
// ----------------------------------------------------------------------------
module riff_wave_header_parser import rwhp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	rwhp_byte_if.sink     file_bytes,
	rwhp_header_if.source header
);

	logic      byte_vld_s1;
	byte_req_t byte_s1;
	logic      emit;
	logic      advance;
	header_t   result;
	header_t   hdr_q;
	logic      hdr_vld_q;

	// stage 1 moves into the walker unless it raises a header the output
	// register cannot take yet
	assign advance = byte_vld_s1 && (!emit || !hdr_vld_q || header.ready);
	assign file_bytes.ready = !byte_vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_vld_s1 <= 1'b0;
		end else if (file_bytes.ready) begin
			byte_vld_s1 <= file_bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (file_bytes.ready && file_bytes.valid) begin
			byte_s1.file_byte   <= file_bytes.file_byte;
			byte_s1.end_of_file <= file_bytes.end_of_file;
		end
	end

	rwhp_parse_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.req    (byte_s1),
		.emit   (emit),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_vld_q <= 1'b0;
		end else if (advance && emit) begin
			hdr_vld_q <= 1'b1;
		end else if (header.ready) begin
			hdr_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			hdr_q <= result;
		end
	end

	assign header.valid           = hdr_vld_q;
	assign header.audio_format    = hdr_q.audio_format;
	assign header.channel_count   = hdr_q.channel_count;
	assign header.sample_rate     = hdr_q.sample_rate;
	assign header.byte_rate       = hdr_q.byte_rate;
	assign header.block_align     = hdr_q.block_align;
	assign header.bits_per_sample = hdr_q.bits_per_sample;
	assign header.data_length     = hdr_q.data_length;
	assign header.data_offset     = hdr_q.data_offset;
	assign header.is_streamed     = hdr_q.is_streamed;
	assign header.header_ok       = hdr_q.header_ok;
	assign header.data_found      = hdr_q.data_found;

endmodule
